// File: rtl/core/fsqra_pkg.sv
`default_nettype none

package fsqra_pkg;

    // window depth and the widths that follow from it
    localparam int WINDOW_FRAMES = 15;
    localparam int LEN_W         = 24;
    localparam int POS_W         = $clog2(WINDOW_FRAMES);
    localparam int SUM_W         = LEN_W + $clog2(WINDOW_FRAMES);

    // register widths
    localparam int LIMIT_W  = 28;
    localparam int PERIOD_W = 16;
    localparam int QP_W     = 6;
    localparam int STEP_W   = 4;
    localparam int CMP_W    = (SUM_W > LIMIT_W) ? SUM_W : LIMIT_W;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = LIMIT_W;

    localparam logic [CFG_ADDR_W-1:0] REG_SIZE_LIMIT = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD_MS  = CFG_ADDR_W'(1);
    localparam logic [CFG_ADDR_W-1:0] REG_QP_CEILING = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] REG_QP_FLOOR   = CFG_ADDR_W'(3);
    localparam logic [CFG_ADDR_W-1:0] REG_RAISE_STEP = CFG_ADDR_W'(4);

    // request kinds
    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // reset values
    localparam logic [LIMIT_W-1:0]  RST_SIZE_LIMIT = LIMIT_W'(512 * 1024);
    localparam logic [PERIOD_W-1:0] RST_PERIOD_MS  = PERIOD_W'(1000);
    localparam logic [QP_W-1:0]     RST_QP_CEILING = QP_W'(51);
    localparam logic [QP_W-1:0]     RST_QP_FLOOR   = QP_W'(35);
    localparam logic [STEP_W-1:0]   RST_RAISE_STEP = STEP_W'(5);
    localparam logic [QP_W-1:0]     RST_STAT_LO    = QP_W'(31);
    localparam logic [QP_W-1:0]     RST_STAT_HI    = QP_W'(35);
    localparam logic [QP_W-1:0]     RST_DYN_LO     = QP_W'(32);
    localparam logic [QP_W-1:0]     RST_DYN_HI     = QP_W'(34);

    // result payload width, four qp fields
    localparam int OUT_DATA_W = 4 * QP_W;

    typedef struct packed {
        logic [LIMIT_W-1:0]  size_limit;
        logic [PERIOD_W-1:0] period_ms;
        logic [QP_W-1:0]     qp_ceiling;
        logic [QP_W-1:0]     qp_floor;
        logic [STEP_W-1:0]   raise_step;
    } cfg_t;

    typedef struct packed {
        logic [QP_W-1:0] stat_lo;
        logic [QP_W-1:0] stat_hi;
        logic [QP_W-1:0] dyn_lo;
        logic [QP_W-1:0] dyn_hi;
    } qp_set_t;

    typedef struct packed {
        logic frame;
        logic tick;
    } evt_t;

    typedef struct packed {
        logic    valid;
        logic    release_res;
        qp_set_t qp;
    } res_t;

endpackage

`default_nettype wire

// File: rtl/core/frame_size_qp_range_adjuster_core.sv
`default_nettype none

// frame size driven qp range adjuster. each request is either a frame size report
// (s_tuser low, byte count in s_tdata) or a one millisecond tick (s_tuser high).
// frame sizes feed a 15-deep ring with a running byte sum; ticks count time once
// the first frame has arrived. when a frame lands after the period has run out the
// timer restarts and the window sum is judged against size_limit: at or under it
// the four qp bounds drop by one, or privileged mode is released (m_tuser high,
// qp fields zero) once static max has reached the floor; over it they rise by up
// to raise_step, kept below the ceiling. one request is taken every clock unless a
// held result stalls the input; where a request makes a result, it is written to
// the output register as the request leaves the input register, through the
// combinational sum and qp logic between the input and output registers. a result
// held by m_tready low keeps the next request in the input register, and s_tready
// stays low until the result is taken. the ring comes out of reset empty at once,
// with no clearing sweep. configuration is written through
// cfg_wr_en/cfg_addr/cfg_wdata and must only change while idle.
module frame_size_qp_range_adjuster_core (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_wr_en,
    input  wire logic [fsqra_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  wire logic [fsqra_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // request side
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [fsqra_pkg::LEN_W-1:0]       s_tdata,  // [23:0] frame_len
    input  wire logic                              s_tuser,  // [0] kind
    // result side
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [5:0] out_static_min, [11:6] out_static_max,
    // [17:12] out_dynamic_min, [23:18] out_dynamic_max
    output logic [fsqra_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic                                   m_tuser   // [0] release_res
);
    import fsqra_pkg::*;

    cfg_t             cfg_reg;

    // input register
    logic             in_valid_reg;
    logic             in_kind_reg;
    logic [LEN_W-1:0] in_len_reg;

    // output register
    logic             out_valid_reg;
    logic             out_release_reg;
    qp_set_t          out_qp_reg;

    logic             advance;
    logic             s_accept;
    evt_t             evt;
    res_t             res;
    logic [SUM_W-1:0] sum_next;

    // the held request moves on when the output register is free or being emptied
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    assign evt.frame = advance && (in_kind_reg == KIND_FRAME);
    assign evt.tick  = advance && (in_kind_reg == KIND_TICK);

    // configuration registers, writes outside the map are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.size_limit <= RST_SIZE_LIMIT;
            cfg_reg.period_ms  <= RST_PERIOD_MS;
            cfg_reg.qp_ceiling <= RST_QP_CEILING;
            cfg_reg.qp_floor   <= RST_QP_FLOOR;
            cfg_reg.raise_step <= RST_RAISE_STEP;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_SIZE_LIMIT: cfg_reg.size_limit <= cfg_wdata[LIMIT_W-1:0];
                REG_PERIOD_MS:  cfg_reg.period_ms  <= cfg_wdata[PERIOD_W-1:0];
                REG_QP_CEILING: cfg_reg.qp_ceiling <= cfg_wdata[QP_W-1:0];
                REG_QP_FLOOR:   cfg_reg.qp_floor   <= cfg_wdata[QP_W-1:0];
                REG_RAISE_STEP: cfg_reg.raise_step <= cfg_wdata[STEP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_kind_reg <= s_tuser;
            in_len_reg  <= s_tdata;
        end
    end

    // ring of recent frame sizes and its running sum
    fsqra_window u_window (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .frame_en  (evt.frame),
        .frame_len (in_len_reg),
        .sum_next  (sum_next)
    );

    // timer, evaluation and qp state
    fsqra_qp_ctrl u_qp_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .evt      (evt),
        .cfg      (cfg_reg),
        .sum_next (sum_next),
        .res      (res)
    );

    // output stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res.valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.valid) begin
            out_release_reg <= res.release_res;
            out_qp_reg      <= res.qp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_release_reg;
    assign m_tdata  = {out_qp_reg.dyn_hi, out_qp_reg.dyn_lo,
                       out_qp_reg.stat_hi, out_qp_reg.stat_lo};

endmodule

`default_nettype wire

// File: rtl/core/fsqra_window.sv
`default_nettype none

module fsqra_window (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       frame_en,
    input  wire logic [fsqra_pkg::LEN_W-1:0] frame_len,
    output logic      [fsqra_pkg::SUM_W-1:0] sum_next
);
    import fsqra_pkg::*;

    logic [LEN_W-1:0]         entry_reg [WINDOW_FRAMES];
    logic [WINDOW_FRAMES-1:0] valid_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [POS_W-1:0]         pos_next;
    logic [SUM_W-1:0]         sum_reg;
    logic [LEN_W-1:0]         old_len;

    // never-written slots count as zero
    assign old_len  = valid_reg[pos_reg] ? entry_reg[pos_reg] : '0;
    assign sum_next = sum_reg - SUM_W'(old_len) + SUM_W'(frame_len);
    assign pos_next = (pos_reg == POS_W'(WINDOW_FRAMES - 1)) ? '0 : pos_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= '0;
            sum_reg   <= '0;
            valid_reg <= '0;
        end else if (frame_en) begin
            pos_reg            <= pos_next;
            sum_reg            <= sum_next;
            valid_reg[pos_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_en) begin
            entry_reg[pos_reg] <= frame_len;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fsqra_qp_ctrl.sv
`default_nettype none

module fsqra_qp_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire fsqra_pkg::evt_t             evt,
    input  wire fsqra_pkg::cfg_t             cfg,
    input  wire logic [fsqra_pkg::SUM_W-1:0] sum_next,
    output fsqra_pkg::res_t                  res
);
    import fsqra_pkg::*;

    logic                  started_reg;
    logic [PERIOD_W-1:0]   elapsed_reg;
    logic [PERIOD_W-1:0]   elapsed_next;
    logic [PERIOD_W-1:0]   elapsed_now;
    qp_set_t               qp_reg;
    qp_set_t               qp_next;
    qp_set_t               qp_shifted;
    logic                  due;
    logic                  over;
    logic                  can_lower;
    logic                  release_now;
    logic signed [QP_W+1:0] room;
    logic signed [QP_W+1:0] step_s;
    logic signed [QP_W+1:0] delta;
    logic [QP_W-1:0]       shift;

    assign elapsed_now = started_reg ? elapsed_reg : '0;
    assign due         = evt.frame && (elapsed_now >= cfg.period_ms);
    assign over        = CMP_W'(sum_next) > CMP_W'(cfg.size_limit);
    assign can_lower   = qp_reg.stat_hi > cfg.qp_floor;
    assign release_now = due && !over && !can_lower;

    // headroom below the ceiling, may be negative
    assign room   = $signed((QP_W+2)'(cfg.qp_ceiling)) - $signed((QP_W+2)'(1))
                  - $signed((QP_W+2)'(qp_reg.stat_hi));
    assign step_s = $signed((QP_W+2)'(cfg.raise_step));

    always_comb begin
        if (over) begin
            delta = (room < step_s) ? room : step_s;
        end else begin
            delta = -$signed((QP_W+2)'(1));
        end
    end

    // all bounds wrap modulo 64
    assign shift = delta[QP_W-1:0];
    assign qp_shifted.stat_lo = qp_reg.stat_lo + shift;
    assign qp_shifted.stat_hi = qp_reg.stat_hi + shift;
    assign qp_shifted.dyn_lo  = qp_reg.dyn_lo + shift;
    assign qp_shifted.dyn_hi  = qp_reg.dyn_hi + shift;

    assign qp_next = (due && !release_now) ? qp_shifted : qp_reg;

    always_comb begin
        elapsed_next = elapsed_reg;
        if (evt.tick) begin
            if (started_reg && (elapsed_reg != '1)) begin
                elapsed_next = elapsed_reg + 1'b1;
            end
        end else if (evt.frame) begin
            elapsed_next = due ? '0 : elapsed_now;
        end
    end

    assign res.valid       = due;
    assign res.release_res = release_now;
    assign res.qp          = release_now ? '0 : qp_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg    <= 1'b0;
            elapsed_reg    <= '0;
            qp_reg.stat_lo <= RST_STAT_LO;
            qp_reg.stat_hi <= RST_STAT_HI;
            qp_reg.dyn_lo  <= RST_DYN_LO;
            qp_reg.dyn_hi  <= RST_DYN_HI;
        end else begin
            started_reg <= started_reg | evt.frame;
            elapsed_reg <= elapsed_next;
            qp_reg      <= qp_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/fsqra_checker.sv
`default_nettype none

module fsqra_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              cfg_wr_en,
    input wire logic [fsqra_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input wire logic [fsqra_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic [fsqra_pkg::LEN_W-1:0]       s_tdata,
    input wire logic                              s_tuser,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [fsqra_pkg::OUT_DATA_W-1:0]  m_tdata,
    input wire logic                              m_tuser
);

    // a waiting result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a release carries no qp range
    a_release_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("release result with non-zero qp fields");

    // a fresh result always traces back to an accepted request
    a_result_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a preceding request");

endmodule

bind frame_size_qp_range_adjuster_core fsqra_checker u_fsqra_checker (.*);

`default_nettype wire
